@@ hw/rtl/gant_pkg.sv @@
`timescale 1ns / 1ps

package gant_pkg;

	localparam int COUNT_W    = 8;
	localparam int START_W    = 7;
	localparam int POS_OUT_W  = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [COUNT_W-1:0] ROW_COUNT_RST = 8'd128;
	localparam logic [COUNT_W-1:0] COL_COUNT_RST = 8'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_COL_COUNT = 2'd1,
		REG_START_ROW = 2'd2,
		REG_START_COL = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		HEAD_UP    = 2'd0,
		HEAD_RIGHT = 2'd1,
		HEAD_DOWN  = 2'd2,
		HEAD_LEFT  = 2'd3
	} heading_t;

endpackage

@@ hw/rtl/grid_ant_automaton_step_core.sv @@
`timescale 1ns / 1ps

// Langton's ant on a toroidal grid of up to MAX_ROWS x MAX_COLS cells held in one
// single-port-write, registered-read memory. Each request with advance set runs one
// generation: the ant's cell is read in the accept cycle, then flipped, the ant turned
// and moved, and the result loaded into the output register once that register is free.
// A new request is taken only after the last one has left the read stage, as set by the
// read-modify-write loop on the grid memory: the next cell address depends on the
// move just made. A request with advance clear only reports the ant's state. After
// reset the memory is swept to white, one cell per cycle, over all MAX_ROWS * MAX_COLS
// cells; in_ready stays low during the sweep while configuration writes are taken.
// Out-of-range counts are clamped to 1..MAX, and start or ant positions beyond the
// counts in use saturate to the last row or column.
module grid_ant_automaton_step_core
	import gant_pkg::*;
#(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  advance,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_OUT_W-1:0]  painted_row,
	output logic [POS_OUT_W-1:0]  painted_col,
	output logic                  painted_black,
	output logic                  did_paint,
	output logic [POS_OUT_W-1:0]  ant_row,
	output logic [POS_OUT_W-1:0]  ant_col,
	output logic [1:0]            heading
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int RCW   = ($clog2(MAX_ROWS + 1) > COUNT_W) ? $clog2(MAX_ROWS + 1) : COUNT_W;
	localparam int CCW   = ($clog2(MAX_COLS + 1) > COUNT_W) ? $clog2(MAX_COLS + 1) : COUNT_W;

	logic [COUNT_W-1:0] row_count_q, col_count_q;
	logic [START_W-1:0] start_row_q, start_col_q;

	logic [RW-1:0] pos_row_q;
	logic [CW-1:0] pos_col_q;
	heading_t      facing_q;
	logic          moved_q;

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	logic          valid_s1;
	logic          adv_s1;
	logic [RW-1:0] r_s1;
	logic [CW-1:0] c_s1;
	logic [AW-1:0] addr_s1;
	logic          cell_s1;

	logic                 out_valid_q;
	logic [POS_OUT_W-1:0] painted_row_q, painted_col_q, ant_row_q, ant_col_q;
	logic                 painted_black_q, did_paint_q;
	heading_t             heading_q;

	logic grid_mem [DEPTH];

	logic [RCW-1:0] rows, sr_ext, r_sat;
	logic [CCW-1:0] cols, sc_ext, c_sat;
	logic [AW-1:0]  rd_addr;
	logic           in_acc, done_s1;

	logic [RCW-1:0] r_ext, r_next;
	logic [CCW-1:0] c_ext, c_next;
	heading_t       face_turn, face_new;

	logic           mem_we, mem_wdata;
	logic [AW-1:0]  mem_waddr;

	assign cfg_ready = 1'b1;
	assign in_ready  = !clearing_q && !valid_s1;
	assign in_acc    = in_valid && in_ready;
	assign done_s1   = valid_s1 && (!out_valid_q || out_ready);

	// clamp counts and saturate the ant position
	always_comb begin
		if (row_count_q == '0)
			rows = RCW'(1);
		else if (RCW'(row_count_q) > RCW'(MAX_ROWS))
			rows = RCW'(MAX_ROWS);
		else
			rows = RCW'(row_count_q);

		if (col_count_q == '0)
			cols = CCW'(1);
		else if (CCW'(col_count_q) > CCW'(MAX_COLS))
			cols = CCW'(MAX_COLS);
		else
			cols = CCW'(col_count_q);

		sr_ext = moved_q ? RCW'(pos_row_q) : RCW'(start_row_q);
		sc_ext = moved_q ? CCW'(pos_col_q) : CCW'(start_col_q);
		r_sat  = (sr_ext >= rows) ? rows - RCW'(1) : sr_ext;
		c_sat  = (sc_ext >= cols) ? cols - CCW'(1) : sc_ext;
		rd_addr = AW'(AW'(RW'(r_sat)) * AW'(MAX_COLS) + AW'(CW'(c_sat)));
	end

	// turn, paint and move
	always_comb begin
		r_ext     = RCW'(r_s1);
		c_ext     = CCW'(c_s1);
		face_turn = cell_s1 ? heading_t'(facing_q - 2'd1) : heading_t'(facing_q + 2'd1);
		face_new  = adv_s1 ? face_turn : facing_q;
		r_next    = r_ext;
		c_next    = c_ext;
		if (adv_s1) begin
			case (face_turn)
				HEAD_UP: begin
					r_next = (r_ext == '0) ? rows - RCW'(1) : r_ext - RCW'(1);
				end
				HEAD_RIGHT: begin
					c_next = (c_ext + CCW'(1) >= cols) ? '0 : c_ext + CCW'(1);
				end
				HEAD_DOWN: begin
					r_next = (r_ext + RCW'(1) >= rows) ? '0 : r_ext + RCW'(1);
				end
				default: begin
					c_next = (c_ext == '0) ? cols - CCW'(1) : c_ext - CCW'(1);
				end
			endcase
		end

		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = 1'b0;
		end else begin
			mem_we    = done_s1 && adv_s1;
			mem_waddr = addr_s1;
			mem_wdata = !cell_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			grid_mem[mem_waddr] <= mem_wdata;
		if (in_acc && advance)
			cell_s1 <= grid_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
			start_row_q <= '0;
			start_col_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data;
				REG_COL_COUNT: col_count_q <= cfg_data;
				REG_START_ROW: start_row_q <= cfg_data[START_W-1:0];
				REG_START_COL: start_col_q <= cfg_data[START_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(DEPTH - 1))
				clearing_q <= 1'b0;
			else
				clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			adv_s1  <= advance;
			r_s1    <= RW'(r_sat);
			c_s1    <= CW'(c_sat);
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q <= '0;
			pos_col_q <= '0;
			facing_q  <= HEAD_UP;
			moved_q   <= 1'b0;
		end else if (done_s1) begin
			pos_row_q <= RW'(r_next);
			pos_col_q <= CW'(c_next);
			facing_q  <= face_new;
			if (adv_s1)
				moved_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			painted_row_q   <= adv_s1 ? POS_OUT_W'(r_ext) : '0;
			painted_col_q   <= adv_s1 ? POS_OUT_W'(c_ext) : '0;
			painted_black_q <= adv_s1 && !cell_s1;
			did_paint_q     <= adv_s1;
			ant_row_q       <= POS_OUT_W'(r_next);
			ant_col_q       <= POS_OUT_W'(c_next);
			heading_q       <= face_new;
		end
	end

	assign out_valid     = out_valid_q;
	assign painted_row   = painted_row_q;
	assign painted_col   = painted_col_q;
	assign painted_black = painted_black_q;
	assign did_paint     = did_paint_q;
	assign ant_row       = ant_row_q;
	assign ant_col       = ant_col_q;
	assign heading       = heading_q;

endmodule
